// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the bit engine modules
// no dependencies; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, quiet while reset is held
`define CHK_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// same check with no reset qualifier
`define CHK_PROP_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/i2cmbe_pkg.sv =====
// shared types and constants for the i2c master bit engine
// no dependencies; used by front, back and top level
package i2cmbe_pkg;

    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // command codes
    localparam logic [2:0] CMD_START  = 3'd0;
    localparam logic [2:0] CMD_STOP   = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_TX_ACK = 3'd4;
    localparam logic [2:0] CMD_RX_ACK = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCL_HOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SDA_HOLD = 1'b1;

    localparam logic [HOLD_W-1:0] SCL_HOLD_RESET = 16'd5;
    localparam logic [HOLD_W-1:0] SDA_HOLD_RESET = 16'd1;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rx_ack;
    } t_out_item;

    // queue entry: the item plus the front's verdict on it
    typedef struct packed {
        t_in_item item;
        logic     start_ok;
    } t_q_entry;

    typedef struct packed {
        logic [HOLD_W-1:0] scl_hold;
        logic [HOLD_W-1:0] sda_hold;
    } t_cfg;

endpackage

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// i2c master bit engine: one item per bus tick in, one result item per tick out
// a result is registered in the output register after its item has passed through the front queue
// throughput: one item per clock while the output is not stalled; the back end steps once per item
// the front queue and the output register let either side stall on its own
// reset (synchronous, active low): lines released, engine idle, holds 5 and 1
// depends on i2cmbe_pkg, i2cmbe_front and i2cmbe_back
module i2c_master_bit_engine #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  i2cmbe_pkg::t_in_item                  i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output i2cmbe_pkg::t_out_item                 o_out_item,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [i2cmbe_pkg::HOLD_W-1:0]         i_cfg_data
);

    logic [i2cmbe_pkg::HOLD_W-1:0] r_scl_hold;
    logic [i2cmbe_pkg::HOLD_W-1:0] r_sda_hold;
    i2cmbe_pkg::t_cfg              cfg;
    logic                          q_valid;
    logic                          q_pop;
    i2cmbe_pkg::t_q_entry          q_entry;

    assign o_cfg_ready  = 1'b1;
    assign cfg.scl_hold = r_scl_hold;
    assign cfg.sda_hold = r_sda_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_hold <= i2cmbe_pkg::SCL_HOLD_RESET;
            r_sda_hold <= i2cmbe_pkg::SDA_HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                i2cmbe_pkg::CFG_SCL_HOLD: r_scl_hold <= i_cfg_data;
                i2cmbe_pkg::CFG_SDA_HOLD: r_sda_hold <= i_cfg_data;
                default:                  r_scl_hold <= r_scl_hold;
            endcase
        end
    end

    i2cmbe_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    i2cmbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hw/rtl/i2cmbe_front.sv =====
// front end: accepts items, marks valid commands, queues them for the engine
// depends on i2cmbe_pkg and assert_macros.svh
`include "assert_macros.svh"

module i2cmbe_front #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  i2cmbe_pkg::t_in_item i_in_item,
    output logic                 o_q_valid,
    output i2cmbe_pkg::t_q_entry o_q_entry,
    input  logic                 i_q_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    i2cmbe_pkg::t_q_entry r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push, pop;
    i2cmbe_pkg::t_q_entry new_entry;

    assign o_in_stall = (r_count == CNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && (r_count != '0);
    assign o_q_valid  = (r_count != '0);
    assign o_q_entry  = r_queue[r_rd_ptr];

    always_comb begin
        new_entry.item     = i_in_item;
        // only a well formed command can start the engine
        new_entry.start_ok = i_in_item.cmd_valid && (i_in_item.kind <= i2cmbe_pkg::CMD_RX_ACK);
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_entry;
        end
    end

    `CHK_PROP(a_count_bounded, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `CHK_PROP(a_count_up, i_clk, i_rst_n, (push && !pop) |=> (r_count > $past(r_count)), "push lost")
    `CHK_PROP(a_pop_has_data, i_clk, i_rst_n, i_q_pop |-> (r_count != '0), "pop from empty queue")

endmodule

// ===== hw/rtl/i2cmbe_back.sv =====
// back end: steps the bit sequencer once per queued item, registers the result
// depends on i2cmbe_pkg and assert_macros.svh
`include "assert_macros.svh"

module i2cmbe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2cmbe_pkg::t_cfg      i_cfg,
    input  logic                  i_q_valid,
    input  i2cmbe_pkg::t_q_entry  i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output i2cmbe_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {
        PRIM_SCL,
        PRIM_SDA,
        PRIM_RD
    } t_prim_kind;

    typedef struct packed {
        t_prim_kind kind;
        logic       lvl;
    } t_prim;

    function automatic logic [4:0] seq_len(input logic [2:0] cmd);
        logic [4:0] len;
        unique case (cmd)
            i2cmbe_pkg::CMD_START:  len = 5'd4;
            i2cmbe_pkg::CMD_STOP:   len = 5'd3;
            i2cmbe_pkg::CMD_WRITE:  len = 5'd24;
            i2cmbe_pkg::CMD_READ:   len = 5'd25;
            i2cmbe_pkg::CMD_TX_ACK: len = 5'd3;
            default:                len = 5'd4;
        endcase
        return len;
    endfunction

    // ph is idx mod 3 and bit is idx div 3, kept as counters beside idx
    function automatic t_prim prim_of(input logic [2:0] cmd, input logic [4:0] idx,
                                      input logic [1:0] ph, input logic [2:0] bit_no,
                                      input logic [7:0] tx, input logic ack);
        t_prim      p;
        logic [1:0] rph;
        p.kind = PRIM_SCL;
        p.lvl  = 1'b0;
        rph    = (ph == 2'd0) ? 2'd2 : ph - 2'd1;
        unique case (cmd)
            i2cmbe_pkg::CMD_START: begin
                p.lvl  = (idx < 5'd2);
                p.kind = idx[0] ? PRIM_SCL : PRIM_SDA;
            end
            i2cmbe_pkg::CMD_STOP: begin
                p.lvl  = (idx != 5'd0);
                p.kind = (idx == 5'd1) ? PRIM_SCL : PRIM_SDA;
            end
            i2cmbe_pkg::CMD_WRITE: begin
                if (ph == 2'd0) begin
                    p.kind = PRIM_SDA;
                    p.lvl  = tx[3'd7 - bit_no];
                end else begin
                    p.lvl  = (ph == 2'd1);
                end
            end
            i2cmbe_pkg::CMD_READ: begin
                if (idx == 5'd0) begin
                    p.kind = PRIM_SDA;
                    p.lvl  = 1'b1;
                end else if (rph == 2'd1) begin
                    p.kind = PRIM_RD;
                end else begin
                    p.lvl  = (rph == 2'd0);
                end
            end
            i2cmbe_pkg::CMD_TX_ACK: begin
                if (idx == 5'd0) begin
                    p.kind = PRIM_SDA;
                    p.lvl  = ack;
                end else begin
                    p.lvl  = (idx == 5'd1);
                end
            end
            default: begin
                if (idx == 5'd0) begin
                    p.kind = PRIM_SDA;
                    p.lvl  = 1'b1;
                end else if (idx == 5'd2) begin
                    p.kind = PRIM_RD;
                end else begin
                    p.lvl  = (idx == 5'd1);
                end
            end
        endcase
        return p;
    endfunction

    logic                          r_scl,     n_scl;
    logic                          r_sda,     n_sda;
    logic [2:0]                    r_cmd,     n_cmd;
    logic                          r_running, n_running;
    logic [4:0]                    r_step,    n_step;
    logic [1:0]                    r_ph,      n_ph;
    logic [2:0]                    r_bit,     n_bit;
    logic [i2cmbe_pkg::HOLD_W-1:0] r_hold,    n_hold;
    logic [7:0]                    r_shift,   n_shift;
    logic                          r_ack_seen, n_ack_seen;
    logic [7:0]                    r_tx,      n_tx;
    logic                          r_ack,     n_ack;
    logic                          r_out_valid;
    i2cmbe_pkg::t_out_item         r_out;

    logic                          pop;
    logic [i2cmbe_pkg::HOLD_W-1:0] hold_dec;
    logic [4:0]                    step_inc;
    logic [1:0]                    ph_inc;
    logic [2:0]                    bit_inc;
    logic                          finish;
    logic                          do_issue;
    logic [2:0]                    eff_cmd;
    logic [4:0]                    eff_idx;
    logic [1:0]                    eff_ph;
    logic [2:0]                    eff_bit;
    logic [7:0]                    eff_tx;
    logic                          eff_ack;
    t_prim                         prim;
    logic [i2cmbe_pkg::HOLD_W-1:0] hold_sel;

    assign pop         = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign hold_dec = (r_hold == '0) ? '0 : r_hold - i2cmbe_pkg::HOLD_W'(1);
    assign step_inc = r_step + 5'd1;
    assign ph_inc   = (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
    assign bit_inc  = (r_ph == 2'd2) ? r_bit + 3'd1 : r_bit;
    assign finish   = r_running && (hold_dec == '0) && (step_inc >= seq_len(r_cmd));
    assign do_issue = r_running ? ((hold_dec == '0) && !finish) : i_q_entry.start_ok;

    // a fresh command issues its first primitive on the accepting tick
    assign eff_cmd = r_running ? r_cmd   : i_q_entry.item.kind;
    assign eff_idx = r_running ? step_inc : 5'd0;
    assign eff_ph  = r_running ? ph_inc  : 2'd0;
    assign eff_bit = r_running ? bit_inc : 3'd0;
    assign eff_tx  = r_running ? r_tx    : i_q_entry.item.tx_byte;
    assign eff_ack = r_running ? r_ack   : i_q_entry.item.ack_out;
    assign prim    = prim_of(eff_cmd, eff_idx, eff_ph, eff_bit, eff_tx, eff_ack);

    always_comb begin
        hold_sel = (prim.kind == PRIM_SCL) ? i_cfg.scl_hold : i_cfg.sda_hold;
        if (hold_sel == '0) begin
            hold_sel = i2cmbe_pkg::HOLD_W'(1);
        end
    end

    always_comb begin
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_cmd      = r_cmd;
        n_running  = r_running;
        n_step     = r_step;
        n_ph       = r_ph;
        n_bit      = r_bit;
        n_hold     = r_hold;
        n_shift    = r_shift;
        n_ack_seen = r_ack_seen;
        n_tx       = r_tx;
        n_ack      = r_ack;
        if (r_running) begin
            n_hold = hold_dec;
            if (hold_dec == '0) begin
                if (finish) begin
                    n_running = 1'b0;
                    n_step    = 5'd0;
                    n_ph      = 2'd0;
                    n_bit     = 3'd0;
                end else begin
                    n_step = step_inc;
                    n_ph   = ph_inc;
                    n_bit  = bit_inc;
                end
            end
        end else if (i_q_entry.start_ok) begin
            n_cmd     = i_q_entry.item.kind;
            n_tx      = i_q_entry.item.tx_byte;
            n_ack     = i_q_entry.item.ack_out;
            n_running = 1'b1;
            n_step    = 5'd0;
            n_ph      = 2'd0;
            n_bit     = 3'd0;
            if (i_q_entry.item.kind == i2cmbe_pkg::CMD_READ) begin
                n_shift = 8'd0;
            end
        end
        if (do_issue) begin
            n_hold = hold_sel;
            unique case (prim.kind)
                PRIM_SCL: n_scl = prim.lvl;
                PRIM_SDA: n_sda = prim.lvl;
                PRIM_RD: begin
                    if (eff_cmd == i2cmbe_pkg::CMD_READ) begin
                        n_shift = {n_shift[6:0], i_q_entry.item.sda_in};
                    end else begin
                        n_ack_seen = i_q_entry.item.sda_in;
                    end
                end
                default: n_hold = hold_sel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_cmd       <= i2cmbe_pkg::CMD_START;
            r_running   <= 1'b0;
            r_step      <= 5'd0;
            r_ph        <= 2'd0;
            r_bit       <= 3'd0;
            r_hold      <= '0;
            r_shift     <= 8'd0;
            r_ack_seen  <= 1'b0;
            r_tx        <= 8'd0;
            r_ack       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_scl      <= n_scl;
                r_sda      <= n_sda;
                r_cmd      <= n_cmd;
                r_running  <= n_running;
                r_step     <= n_step;
                r_ph       <= n_ph;
                r_bit      <= n_bit;
                r_hold     <= n_hold;
                r_shift    <= n_shift;
                r_ack_seen <= n_ack_seen;
                r_tx       <= n_tx;
                r_ack      <= n_ack;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register carries the state as it stands after this item
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.scl      <= n_scl;
            r_out.sda_out  <= n_sda;
            r_out.busy_res <= n_running;
            r_out.done_res <= finish;
            r_out.rx_byte  <= n_shift;
            r_out.rx_ack   <= n_ack_seen;
        end
    end

    `CHK_PROP(a_hold_live, i_clk, i_rst_n, r_running |-> (r_hold != '0), "engine running with no hold")
    `CHK_PROP(a_step_in_seq, i_clk, i_rst_n, r_running |-> (r_step < seq_len(r_cmd)), "step beyond sequence")
    `CHK_PROP(a_done_idle, i_clk, i_rst_n, (r_out_valid && r_out.done_res) |-> !r_out.busy_res, "done while busy")

endmodule
